@@ rtl/esa_pkg.sv @@
`default_nettype none
package esa_pkg;

   // number of event slots (1 to 32)
   localparam int NUM_EVENTS = 32;
   localparam int IDX_W      = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
   localparam int DELAY_W    = 16;
   localparam int MISS_W     = 6;
   localparam int ID_W       = 8;
   localparam int CHOSEN_W   = 5;
   localparam int MASK_W     = 32;
   localparam logic [MISS_W-1:0] MISS_MAX = '1;

   // operation codes of a request beat
   typedef enum logic [1:0] {
      KIND_PUSH     = 2'd0,
      KIND_CLEAR    = 2'd1,
      KIND_TICK     = 2'd2,
      KIND_DISPATCH = 2'd3
   } kind_type;

   // request beat
   typedef struct packed {
      kind_type            kind;
      logic [ID_W-1:0]     event_id;
      logic [DELAY_W-1:0]  delay_ticks;
   } req_type;

   // response beat
   typedef struct packed {
      logic                found;
      logic [CHOSEN_W-1:0] chosen_event;
      logic                has_handler;
   } rsp_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic tick_step;
      logic scan_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic idx_last;
      logic scan_end;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/esa_ctrl.sv @@
`default_nettype none
module esa_ctrl import esa_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire kind_type   req_kind,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_TICK:     state_in = ST_TICK;
                  KIND_DISPATCH: state_in = ST_SCAN;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            if (status.idx_last) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (status.scan_end) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_TICK:   cmd.tick_step = 1'b1;
         ST_SCAN:   cmd.scan_step = 1'b1;
         ST_FINISH: cmd.finish    = status.rsp_free;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/esa_datapath.sv @@
`default_nettype none
module esa_datapath import esa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire req_type           req_data,
   input  wire logic              csr_we,
   input  wire logic [MASK_W-1:0] csr_wdata,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  wire cmd_type           cmd,
   output status_type             status
);

   logic [MASK_W-1:0]     mask_ff;
   logic [NUM_EVENTS-1:0] pending_ff;
   logic [DELAY_W-1:0]    delay_ff [NUM_EVENTS];
   logic [MISS_W-1:0]     miss_ff  [NUM_EVENTS];
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   logic                  have_ff;
   logic                  have_in;
   logic [IDX_W-1:0]      pick_ff;
   logic [IDX_W-1:0]      pick_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  id_ok;
   logic [IDX_W-1:0]      id_idx;
   logic                  elig;
   logic [MISS_W-1:0]     miss_inc;
   logic                  takeover;

   logic                  pend_we;
   logic [IDX_W-1:0]      pend_wa;
   logic                  pend_wd;
   logic                  dly_we;
   logic [IDX_W-1:0]      dly_wa;
   logic [DELAY_W-1:0]    dly_wd;
   logic                  miss_we;
   logic [IDX_W-1:0]      miss_wa;
   logic [MISS_W-1:0]     miss_wd;

   // request decode and scan evaluation at the current slot
   assign id_ok    = req_data.event_id < ID_W'(NUM_EVENTS);
   assign id_idx   = req_data.event_id[IDX_W-1:0];
   assign elig     = pending_ff[idx_ff] && (delay_ff[idx_ff] == '0);
   assign miss_inc = (miss_ff[idx_ff] < MISS_MAX) ? miss_ff[idx_ff] + MISS_W'(1)
                                                  : miss_ff[idx_ff];
   assign takeover = elig && have_ff && (miss_inc > MISS_W'(idx_ff));

   // status to controller
   assign status.idx_last = idx_ff == IDX_W'(NUM_EVENTS - 1);
   assign status.scan_end = status.idx_last || takeover;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // slot counter and scan result
   always_comb begin
      idx_in  = idx_ff;
      have_in = have_ff;
      pick_in = pick_ff;
      if (cmd.accept) begin
         idx_in  = '0;
         have_in = 1'b0;
      end else if (cmd.tick_step) begin
         idx_in = idx_ff + IDX_W'(1);
      end else if (cmd.scan_step) begin
         idx_in = idx_ff + IDX_W'(1);
         if (elig && !have_ff) begin
            have_in = 1'b1;
            pick_in = idx_ff;
         end else if (takeover) begin
            pick_in = idx_ff;
         end
      end
   end

   // one write port per slot table, commands never overlap
   always_comb begin
      pend_we = 1'b0;
      pend_wa = id_idx;
      pend_wd = 1'b0;
      dly_we  = 1'b0;
      dly_wa  = id_idx;
      dly_wd  = req_data.delay_ticks;
      miss_we = 1'b0;
      miss_wa = id_idx;
      miss_wd = '0;
      if (cmd.accept && id_ok && req_data.kind == KIND_PUSH) begin
         pend_we = 1'b1;
         pend_wd = 1'b1;
         dly_we  = 1'b1;
         miss_we = 1'b1;
      end else if (cmd.accept && id_ok && req_data.kind == KIND_CLEAR) begin
         pend_we = 1'b1;
         miss_we = 1'b1;
      end else if (cmd.tick_step) begin
         dly_we = delay_ff[idx_ff] != '0;
         dly_wa = idx_ff;
         dly_wd = delay_ff[idx_ff] - DELAY_W'(1);
      end else if (cmd.scan_step) begin
         miss_we = elig && have_ff;
         miss_wa = idx_ff;
         miss_wd = miss_inc;
      end else if (cmd.finish) begin
         pend_we = have_ff;
         pend_wa = pick_ff;
         miss_we = have_ff;
         miss_wa = pick_ff;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.finish) begin
         rsp_valid_in        = 1'b1;
         rsp_in.found        = have_ff;
         rsp_in.chosen_event = have_ff ? CHOSEN_W'(pick_ff) : '0;
         rsp_in.has_handler  = have_ff && mask_ff[pick_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         have_ff      <= 1'b0;
      end else begin
         if (csr_we) mask_ff <= csr_wdata;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         have_ff      <= have_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pick_ff <= pick_in;
      rsp_ff  <= rsp_in;
   end

   // slot tables
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         for (int i = 0; i < NUM_EVENTS; i++) begin
            delay_ff[i] <= '0;
            miss_ff[i]  <= '0;
         end
      end else begin
         if (pend_we) pending_ff[pend_wa] <= pend_wd;
         if (dly_we)  delay_ff[dly_wa]    <= dly_wd;
         if (miss_we) miss_ff[miss_wa]    <= miss_wd;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a finished scan never overwrites a beat that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");

   // an empty dispatch beat carries no slot
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |->
         (rsp_ff.chosen_event == '0 && !rsp_ff.has_handler))
      else $error("empty dispatch carries a slot");

   // commands are mutually exclusive
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.tick_step, cmd.scan_step, cmd.finish}))
      else $error("overlapping commands");

   // the chosen slot is cleared in the same cycle as the result is loaded
   a_pick_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && have_ff) |=> !pending_ff[$past(pick_ff)])
      else $error("chosen slot still pending");
`endif

endmodule
`default_nettype wire

@@ rtl/event_scheduler_aging_arbiter.sv @@
// Event scheduler with an aging arbiter over NUM_EVENTS slots.
// Request channel (req_valid/req_ready/req_data) carries one beat per
// operation: push (set pending, load delay, zero misses), clear, tick
// (decrement every nonzero delay) or dispatch. Only dispatch produces a
// response beat on rsp_valid/rsp_ready/rsp_data: found, chosen slot and
// its handler bit from the handler mask written through csr_we/csr_wdata.
// Push and clear are done in the idle state. Tick steps through the slots,
// one slot per cycle through the single delay table write port. Dispatch
// scans the slots in order (it stops early on a takeover), then loads
// the response register in its final step.
// One operation is worked on at a time; req_ready is high while idle.
// The response register lets the next request start while a response
// waits; a dispatch that finishes while the previous response is still
// stalled holds in its final step until the receiver takes that beat.
// Synchronous reset clears all slots, the handler mask and the response.
`default_nettype none
module event_scheduler_aging_arbiter import esa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_we,
   input  wire logic [MASK_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   esa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // slot tables, scan and response register
   esa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
`default_nettype wire
